[sv/cpl_pkg.sv]
// Shared types and constants for the closest-point-between-lines core.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpl_pkg;

  // Quotient bits kept below the clamp bit; any |offset| >= 2**33 saturates.
  localparam int CPL_QBITS = 33;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_start_z;
    logic signed [31:0] a_dir_x;
    logic signed [31:0] a_dir_y;
    logic signed [31:0] a_dir_z;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_start_z;
    logic signed [31:0] b_dir_x;
    logic signed [31:0] b_dir_y;
    logic signed [31:0] b_dir_z;
  } cpl_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               degenerate;
  } cpl_out_t;

endpackage

`default_nettype wire

[sv/cpl_mul.sv]
// Two-stage signed multiplier: A is cut into 32-bit chunks, one registered
// partial product per chunk, then a registered shifted sum. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpl_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int NC = (AW + 31) / 32;
  localparam int PW = AW + BW;
  localparam int XW = BW + 33;

  logic signed [NC*32-1:0] ax;
  logic signed [XW-1:0]    part [NC];
  logic signed [PW-1:0]    acc;

  assign ax = (NC*32)'(a);

  // low chunks are unsigned digits, the top chunk carries the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NC; k++) begin
        if (k == NC - 1) begin
          part[k] <= XW'($signed(ax[32*k +: 32]) * b);
        end else begin
          part[k] <= XW'($signed({1'b0, ax[32*k +: 32]}) * b);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (PW'(part[k]) <<< (32 * k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

`default_nettype wire

[sv/cpl_div.sv]
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per
// stage, with a clamp check up front and round-half-up at the end. No deps.
`timescale 1ns / 1ps
`default_nettype none

module cpl_div #(
  parameter int NW = 165,
  parameter int DW = 132,
  parameter int QB = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  n,
  input  logic [DW-1:0]  d,
  output logic [QB:0]    q,
  output logic           sat
);

  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dd  [QB+1];
  logic [QB-1:0] qq  [QB+1];
  logic          st  [QB+1];
  logic          rup;

  // clamp stage: quotient would reach 2**QB
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n;
      dd[0]  <= d;
      qq[0]  <= '0;
      st[0]  <= CW'(n) >= (CW'(d) << QB);
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    localparam int B = QB - i;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(dd[i-1]) << B;
    assign ge    = CW'(rem[i-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? NW'(CW'(rem[i-1]) - trial) : rem[i-1];
        dd[i]  <= dd[i-1];
        qq[i]  <= qq[i-1] | (QB'(ge) << B);
        st[i]  <= st[i-1];
      end
    end
  end

  // remainder is below d here unless clamped
  assign rup = ((DW+1)'(rem[QB][DW-1:0]) << 1) >= (DW+1)'(dd[QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      q   <= (QB+1)'(qq[QB]) + (QB+1)'(rup);
      sat <= st[QB];
    end
  end

endmodule

`default_nettype wire

[sv/closest_point_between_lines_core.sv]
// Closest point on 3D line A to line B, exact fixed point. Each input beat
// carries two lines (start point and direction, signed 32-bit fixed point);
// the output beat carries the point on A nearest to B, rounded to nearest
// (ties away from zero) and saturated to 32 bits, or zero with degenerate
// set when the lines are parallel or a direction is null. The core is a
// 49-stage pipeline that accepts one beat every cycle unless stalled.
// All stages advance together; when the output register holds an
// untaken beat the whole pipeline, input ready included, stalls for
// that cycle. Most of its depth comes from the 33-stage quotient pipeline
// and the four two-stage multiply rounds. Depends on cpl_pkg, cpl_mul and
// cpl_div.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_between_lines_core
  import cpl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cpl_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output cpl_out_t out_item
);

  localparam int NW    = 165;   // |dirA_i * num|
  localparam int DW    = 132;   // |den|
  localparam int S_DIV = 13;    // divider input stage
  localparam int S_END = S_DIV + CPL_QBITS + 2;  // divider output stage
  localparam int S_OUT = S_END + 1;

  typedef struct {
    logic signed [31:0] sa [3];
    logic signed [31:0] da [3];
    logic signed [31:0] sb [3];
    logic signed [31:0] db [3];
    logic signed [32:0] w  [3];
    logic               dz;
  } side_t;

  typedef struct {
    logic signed [31:0] sa  [3];
    logic               neg [3];
    logic               dz;
  } tail_t;

  logic adv;
  logic vld [1:S_OUT];

  side_t side [1:12];
  tail_t tail [S_DIV:S_END];

  logic signed [63:0]  pa [3];
  logic signed [63:0]  pb [3];
  logic signed [64:0]  nrm [3];
  logic signed [96:0]  ma [3];
  logic signed [96:0]  mb [3];
  logic signed [97:0]  mv [3];
  logic signed [130:0] nt [3];
  logic signed [129:0] dt [3];
  logic signed [132:0] num;
  logic signed [131:0] den;
  logic signed [131:0] den11;
  logic signed [131:0] den12;
  logic signed [131:0] den_sum;
  logic signed [164:0] np [3];
  logic [NW-1:0]       nabs [3];
  logic [DW-1:0]       dabs;
  logic [CPL_QBITS:0]  dq [3];
  logic                dsat [3];
  cpl_out_t            res_next;

  // global advance: stall only when the output beat is held
  assign adv       = !vld[S_OUT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= S_OUT; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[1] <= in_valid;
      for (int s = 2; s <= S_OUT; s++) vld[s] <= vld[s-1];
    end
  end

  assign den_sum = 132'(dt[0]) + 132'(dt[1]) + 132'(dt[2]);

  // side-band operands ride along; w formed in stage 2, dz in stage 10
  always_ff @(posedge clk) begin
    if (adv) begin
      side[1].sa[0] <= in_item.a_start_x;
      side[1].sa[1] <= in_item.a_start_y;
      side[1].sa[2] <= in_item.a_start_z;
      side[1].da[0] <= in_item.a_dir_x;
      side[1].da[1] <= in_item.a_dir_y;
      side[1].da[2] <= in_item.a_dir_z;
      side[1].sb[0] <= in_item.b_start_x;
      side[1].sb[1] <= in_item.b_start_y;
      side[1].sb[2] <= in_item.b_start_z;
      side[1].db[0] <= in_item.b_dir_x;
      side[1].db[1] <= in_item.b_dir_y;
      side[1].db[2] <= in_item.b_dir_z;
      for (int s = 2; s <= 12; s++) begin
        side[s].sa <= side[s-1].sa;
        side[s].da <= side[s-1].da;
        side[s].sb <= side[s-1].sb;
        side[s].db <= side[s-1].db;
      end
      for (int i = 0; i < 3; i++) begin
        side[2].w[i] <= 33'(side[1].sb[i]) - 33'(side[1].sa[i]);
      end
      for (int s = 3; s <= 12; s++) side[s].w <= side[s-1].w;
      side[10].dz <= (den_sum == '0);
      for (int s = 11; s <= 12; s++) side[s].dz <= side[s-1].dz;
    end
  end

  // n = dirA x dirB (products out at stage 3, difference at stage 4)
  for (genvar i = 0; i < 3; i++) begin : g_n
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    cpl_mul #(.AW(32), .BW(32)) u_pa (
      .clk(clk), .en(adv), .a(side[1].da[J]), .b(side[1].db[K]), .p(pa[i])
    );
    cpl_mul #(.AW(32), .BW(32)) u_pb (
      .clk(clk), .en(adv), .a(side[1].da[K]), .b(side[1].db[J]), .p(pb[i])
    );
    always_ff @(posedge clk) begin
      if (adv) nrm[i] <= 65'(pa[i]) - 65'(pb[i]);
    end
  end

  // m = n x dirB, plane normal (stage 7)
  for (genvar i = 0; i < 3; i++) begin : g_m
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    cpl_mul #(.AW(65), .BW(32)) u_ma (
      .clk(clk), .en(adv), .a(nrm[J]), .b(side[4].db[K]), .p(ma[i])
    );
    cpl_mul #(.AW(65), .BW(32)) u_mb (
      .clk(clk), .en(adv), .a(nrm[K]), .b(side[4].db[J]), .p(mb[i])
    );
    always_ff @(posedge clk) begin
      if (adv) mv[i] <= 98'(ma[i]) - 98'(mb[i]);
    end
  end

  // num = m . (startB - startA), den = m . dirA (stage 10)
  for (genvar i = 0; i < 3; i++) begin : g_dot
    cpl_mul #(.AW(98), .BW(33)) u_nt (
      .clk(clk), .en(adv), .a(mv[i]), .b(side[7].w[i]), .p(nt[i])
    );
    cpl_mul #(.AW(98), .BW(32)) u_dt (
      .clk(clk), .en(adv), .a(mv[i]), .b(side[7].da[i]), .p(dt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num   <= 133'(nt[0]) + 133'(nt[1]) + 133'(nt[2]);
      den   <= den_sum;
      den11 <= den;
      den12 <= den11;
    end
  end

  // dirA_i * num (stage 12), then magnitudes and signs (stage 13)
  for (genvar i = 0; i < 3; i++) begin : g_np
    cpl_mul #(.AW(133), .BW(32)) u_np (
      .clk(clk), .en(adv), .a(num), .b(side[10].da[i]), .p(np[i])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        nabs[i] <= np[i][164] ? NW'(-np[i]) : NW'(np[i]);
      end
    end
    cpl_div #(.NW(NW), .DW(DW), .QB(CPL_QBITS)) u_div (
      .clk(clk), .en(adv), .n(nabs[i]), .d(dabs), .q(dq[i]), .sat(dsat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dabs <= den12[131] ? DW'(-den12) : DW'(den12);
      for (int i = 0; i < 3; i++) begin
        tail[S_DIV].neg[i] <= np[i][164] ^ den12[131];
        tail[S_DIV].sa[i]  <= side[12].sa[i];
      end
      tail[S_DIV].dz <= side[12].dz;
      for (int s = S_DIV + 1; s <= S_END; s++) tail[s] <= tail[s-1];
    end
  end

  // signed offset, add start point, saturate to 32 bits; zero when degenerate
  always_comb begin
    logic [CPL_QBITS:0]         mag;
    logic signed [CPL_QBITS+1:0] off;
    logic signed [CPL_QBITS+2:0] sum;
    logic signed [31:0]          pt [3];
    for (int i = 0; i < 3; i++) begin
      mag = dsat[i] ? ((CPL_QBITS+1)'(1) << CPL_QBITS) : dq[i];
      off = tail[S_END].neg[i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum = (CPL_QBITS+3)'(tail[S_END].sa[i]) + (CPL_QBITS+3)'(off);
      if (tail[S_END].dz) begin
        pt[i] = '0;
      end else if (sum > (CPL_QBITS+3)'(32'sh7FFF_FFFF)) begin
        pt[i] = 32'sh7FFF_FFFF;
      end else if (sum < (CPL_QBITS+3)'(32'sh8000_0000)) begin
        pt[i] = 32'sh8000_0000;
      end else begin
        pt[i] = sum[31:0];
      end
    end
    res_next.point_x    = pt[0];
    res_next.point_y    = pt[1];
    res_next.point_z    = pt[2];
    res_next.degenerate = tail[S_END].dz;
  end

  always_ff @(posedge clk) begin
    if (adv) out_item <= res_next;
  end

endmodule

`default_nettype wire

[dv/closest_point_between_lines_core_tb.sv]
// Testbench for closest_point_between_lines_core: directed and random line pairs,
// with an exact wide-integer predictor and a scoreboard of expected points.
// Depends on cpl_pkg and the core RTL.
`timescale 1ns / 1ps

module closest_point_between_lines_core_tb;
  import cpl_pkg::*;

  // 256 bits covers every exact product (largest is about 2**164)
  typedef logic signed [255:0] wide_t;

  localparam int N_RANDOM   = 780;
  localparam int STALL_LIM  = 20000;
  localparam int DRAIN_WAIT = 120;

  // Predicts closest points and holds them in arrival order.
  class point_board;
    cpl_out_t pending_points[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function cpl_out_t closest_point(cpl_in_t ln);
      wide_t    sa[3], da[3], sb[3], db[3], w[3], n[3], m[3];
      wide_t    num, den, prod, an, ad, q, r, off, sum;
      logic     neg;
      cpl_out_t res;
      sa = '{ln.a_start_x, ln.a_start_y, ln.a_start_z};
      da = '{ln.a_dir_x, ln.a_dir_y, ln.a_dir_z};
      sb = '{ln.b_start_x, ln.b_start_y, ln.b_start_z};
      db = '{ln.b_dir_x, ln.b_dir_y, ln.b_dir_z};
      for (int i = 0; i < 3; i++) w[i] = sb[i] - sa[i];
      // common normal, then normal of the plane holding line B
      for (int i = 0; i < 3; i++)
        n[i] = da[(i+1)%3] * db[(i+2)%3] - da[(i+2)%3] * db[(i+1)%3];
      for (int i = 0; i < 3; i++)
        m[i] = n[(i+1)%3] * db[(i+2)%3] - n[(i+2)%3] * db[(i+1)%3];
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
        num = num + m[i] * w[i];
        den = den + m[i] * da[i];
      end
      res = '0;
      if (den == 0) begin
        res.degenerate = 1'b1;
        return res;
      end
      for (int i = 0; i < 3; i++) begin
        prod = da[i] * num;
        neg  = (prod < 0) != (den < 0);
        an   = (prod < 0) ? -prod : prod;
        ad   = (den < 0) ? -den : den;
        q    = an / ad;
        r    = an % ad;
        if (2 * r >= ad) q = q + 1;  // ties away from zero
        off = neg ? -q : q;
        sum = sa[i] + off;
        if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
        else if (sum < -64'sh80000000) sum = -64'sh80000000;
        case (i)
          0: res.point_x = sum[31:0];
          1: res.point_y = sum[31:0];
          default: res.point_z = sum[31:0];
        endcase
      end
      return res;
    endfunction

    function void note_lines(cpl_in_t ln);
      pending_points.push_back(closest_point(ln));
    endfunction

    function void check_point(cpl_out_t got);
      cpl_out_t exp_pt;
      if (pending_points.size() == 0) begin
        $error("unexpected output beat: x=%0d y=%0d z=%0d deg=%0b",
               got.point_x, got.point_y, got.point_z, got.degenerate);
        errors++;
        return;
      end
      exp_pt = pending_points.pop_front();
      if (got.point_x !== exp_pt.point_x) begin
        $error("point_x: expected %0d, got %0d", exp_pt.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== exp_pt.point_y) begin
        $error("point_y: expected %0d, got %0d", exp_pt.point_y, got.point_y);
        errors++;
      end
      if (got.point_z !== exp_pt.point_z) begin
        $error("point_z: expected %0d, got %0d", exp_pt.point_z, got.point_z);
        errors++;
      end
      if (got.degenerate !== exp_pt.degenerate) begin
        $error("degenerate: expected %0b, got %0b", exp_pt.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cpl_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cpl_out_t out_item;

  point_board board = new();
  int  beat_no = 0;      // input beats accepted so far
  int  quiet_cycles = 0; // cycles with no beat on either side
  bit  moved;
  bit  send_done = 1'b0;

  always #2 clk = ~clk;

  closest_point_between_lines_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Idle roughly 36% of the time, except in a quiet window mid-run.
  function automatic bit take_gap();
    if (beat_no >= 300 && beat_no < 480) return 1'b0;
    return $urandom_range(0, 99) < 36;
  endfunction

  // Coordinate mix: full range, scaled-down, extremes, small, zero.
  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1: return v;
      2, 3, 4: return v >>> $urandom_range(8, 28);
      5: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      6: return $signed($urandom_range(0, 6)) - 3;
      default: return 0;
    endcase
  endfunction

  function automatic cpl_in_t rand_lines();
    cpl_in_t ln;
    int      k;
    ln = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: begin  // parallel: B dir is a small multiple of A dir
        k = $urandom_range(0, 6) - 3;
        ln.a_dir_x = ln.a_dir_x >>> 4;
        ln.a_dir_y = ln.a_dir_y >>> 4;
        ln.a_dir_z = ln.a_dir_z >>> 4;
        ln.b_dir_x = ln.a_dir_x * k;
        ln.b_dir_y = ln.a_dir_y * k;
        ln.b_dir_z = ln.a_dir_z * k;
      end
      1: {ln.a_dir_x, ln.a_dir_y, ln.a_dir_z} = '0;  // null direction
      2: begin  // lines that meet: B starts on A
        ln.b_start_x = ln.a_start_x;
        ln.b_start_y = ln.a_start_y;
        ln.b_start_z = ln.a_start_z;
      end
      default: ;
    endcase
    return ln;
  endfunction

  // Offer one beat and hold it until taken; ready is checked mid-cycle.
  task automatic send_lines(cpl_in_t ln);
    in_valid <= 1'b1;
    in_item  <= ln;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    board.note_lines(ln);
    beat_no++;
    if (take_gap()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (take_gap());
    end
  endtask

  function automatic cpl_in_t mk(logic signed [31:0] sx, sy, sz, dx, dy, dz,
                                 tx, ty, tz, ex, ey, ez);
    return {sx, sy, sz, dx, dy, dz, tx, ty, tz, ex, ey, ez};
  endfunction

  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  // Sender
  initial begin
    cpl_in_t directed[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // all zero: null directions
    directed.push_back('0);
    // skew axes: A along x at origin, B along y through z=1
    directed.push_back(mk(0, 0, 0, ONE, 0, 0, 5*ONE, 0, ONE, 0, ONE, 0));
    // parallel lines
    directed.push_back(mk(0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 2*ONE, 2*ONE, 0));
    // null B direction
    directed.push_back(mk(ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    // lines that meet
    directed.push_back(mk(ONE, 2*ONE, 3*ONE, ONE, 0, ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0));
    // half-step line parameters with exact offsets, both signs
    directed.push_back(mk(0, 0, 0, 2, 0, 0, 1, 0, 7, 0, 1, 0));
    directed.push_back(mk(0, 0, 0, 2, 0, 0, -1, 0, 7, 0, 1, 0));
    directed.push_back(mk(0, 0, 0, 2, 0, 0, 3, 0, -7, 0, -1, 0));
    // results exactly at the 32-bit limits, high and low
    directed.push_back(mk(MAXV, 0, 0, ONE, 0, 0, MINV, 0, ONE, 0, ONE, 0));
    directed.push_back(mk(MINV, 0, 0, ONE, 0, 0, MAXV, 0, ONE, 0, ONE, 0));
    directed.push_back(mk(MAXV, MINV, MAXV, 1, -1, 0, MINV, MAXV, MINV, 0, 0, 1));
    // extreme fields everywhere, then mixes with small values
    directed.push_back(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MAXV, MAXV));
    directed.push_back(mk(MINV, MAXV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MINV, MAXV));
    directed.push_back(mk(MINV, MINV, MINV, MINV, 1, -1, -1, MAXV, 0, 1, MINV, MINV));
    directed.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 1));
    foreach (directed[i]) send_lines(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) send_lines(rand_lines());
    in_valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: check mid-cycle, change ready at the edge. A long hold-off
  // early in the random part backs the pipeline up into in_ready.
  initial begin
    bit held = 1'b0;
    forever begin
      @(negedge clk);
      if (out_valid && out_ready) board.check_point(out_item);
      @(posedge clk);
      if (!held && beat_no >= 60) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      out_ready <= !take_gap();
    end
  end

  // Watchdog: any accepted beat resets the count
  always @(negedge clk) begin
    moved = (in_valid && in_ready) || (out_valid && out_ready);
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("closest_point_between_lines_core_tb: FAIL");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (send_done);
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("closest_point_between_lines_core_tb: PASS");
    end else begin
      $display("closest_point_between_lines_core_tb: FAIL");
    end
    $finish;
  end

endmodule
